/* design/srtlsp_pkg.sv */
package srtlsp_pkg;

    // Time unit factors
    localparam int MS_PER_SEC  = 1000;
    localparam int SEC_PER_MIN = 60;
    localparam int MS_PER_MIN  = MS_PER_SEC * SEC_PER_MIN;
    localparam int MS_PER_HOUR = MS_PER_MIN * SEC_PER_MIN;

    localparam int MS_W     = 29;
    localparam int WEIGHT_W = 26;
    localparam int CUE_W    = 16;

    // Line kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_INDEX   = 3'd1;
    localparam logic [2:0] KIND_TIME    = 3'd2;
    localparam logic [2:0] KIND_CONTENT = 3'd3;
    localparam logic [2:0] KIND_BLANK   = 3'd4;

    // Time line pattern positions
    localparam logic [4:0] POS_SEP   = 5'd12;
    localparam logic [4:0] POS_DASH2 = 5'd13;
    localparam logic [4:0] POS_GT    = 5'd14;
    localparam logic [4:0] POS_PRE2  = 5'd15;
    localparam logic [4:0] POS_T2    = 5'd16;
    localparam logic [4:0] POS_DONE  = 5'd28;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       line_type;
        logic             error;
        logic [MS_W-1:0]  start_ms;
        logic [MS_W-1:0]  end_ms;
        logic [CUE_W-1:0] cue_count;
        logic             joins_previous;
    } t_out_item;

    typedef struct packed {
        logic char_en;
        logic line_clr;
    } t_tm_ctrl;

    // Weight of each character of HH:MM:SS,mmm; zero marks a separator
    function automatic logic [WEIGHT_W-1:0] time_weight(input logic [3:0] q);
        logic [WEIGHT_W-1:0] w;
        case (q)
            4'd0:    w = WEIGHT_W'(10 * MS_PER_HOUR);
            4'd1:    w = WEIGHT_W'(MS_PER_HOUR);
            4'd3:    w = WEIGHT_W'(10 * MS_PER_MIN);
            4'd4:    w = WEIGHT_W'(MS_PER_MIN);
            4'd6:    w = WEIGHT_W'(10 * MS_PER_SEC);
            4'd7:    w = WEIGHT_W'(MS_PER_SEC);
            4'd9:    w = WEIGHT_W'(100);
            4'd10:   w = WEIGHT_W'(10);
            4'd11:   w = WEIGHT_W'(1);
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] time_sep(input logic [3:0] q);
        logic [7:0] s;
        case (q)
            4'd2, 4'd5: s = CH_COLON;
            4'd8:       s = CH_COMMA;
            default:    s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

/* design/srtlsp_time_match.sv */
module srtlsp_time_match (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  srtlsp_pkg::t_tm_ctrl    i_ctrl,
    input  logic [7:0]              i_ch,
    output logic                    o_done,
    output logic [srtlsp_pkg::MS_W-1:0] o_start_ms,
    output logic [srtlsp_pkg::MS_W-1:0] o_end_ms
);
    import srtlsp_pkg::*;

    logic [4:0]          r_pos, n_pos;
    logic                r_ok, n_ok;
    logic [MS_W-1:0]     r_start, n_start;
    logic [MS_W-1:0]     r_end, n_end;

    logic                w_first;
    logic [3:0]          w_q;
    logic [WEIGHT_W-1:0] w_weight;
    logic                w_is_num;
    logic                w_tc_ok;
    logic [3:0]          w_dval;
    logic [MS_W-1:0]     w_prod;
    logic [MS_W-1:0]     w_sum;

    // Select the time stamp character slot
    assign w_first  = (r_pos < POS_SEP);
    assign w_q      = (r_pos == POS_PRE2) ? 4'd0 : r_pos[3:0];
    assign w_weight = time_weight(w_q);
    assign w_is_num = (w_weight != '0);
    assign w_tc_ok  = w_is_num ? is_digit(i_ch) : (i_ch == time_sep(w_q));

    // Accumulate the weighted digit into the selected time
    assign w_dval = 4'(i_ch - CH_ZERO);
    assign w_prod = MS_W'(w_dval) * MS_W'(w_weight);
    assign w_sum  = (w_first ? r_start : r_end) + w_prod;

    // Advance the pattern by one character, or clear it at end of line
    always_comb begin
        n_pos   = r_pos;
        n_ok    = r_ok;
        n_start = r_start;
        n_end   = r_end;
        if (i_ctrl.line_clr) begin
            n_pos   = '0;
            n_ok    = 1'b1;
            n_start = '0;
            n_end   = '0;
        end else if (i_ctrl.char_en && r_ok) begin
            if (w_first) begin
                if (w_tc_ok) begin
                    n_pos   = r_pos + 5'd1;
                    n_start = w_sum;
                end else begin
                    n_ok = 1'b0;
                end
            end else if (r_pos == POS_SEP) begin
                if (i_ch == CH_DASH) begin
                    n_pos = POS_DASH2;
                end else if (!is_space(i_ch)) begin
                    n_ok = 1'b0;
                end
            end else if (r_pos == POS_DASH2) begin
                if (i_ch == CH_DASH) n_pos = POS_GT;
                else n_ok = 1'b0;
            end else if (r_pos == POS_GT) begin
                if (i_ch == CH_GT) n_pos = POS_PRE2;
                else n_ok = 1'b0;
            end else if ((r_pos == POS_PRE2) && is_space(i_ch)) begin
                n_pos = r_pos;
            end else if (r_pos < POS_DONE) begin
                if (w_tc_ok) begin
                    n_pos = POS_T2 + 5'(w_q) + 5'd1;
                    n_end = w_sum;
                end else begin
                    n_ok = 1'b0;
                end
            end else begin
                n_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ok    <= 1'b1;
            r_start <= '0;
            r_end   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_ok    <= n_ok;
            r_start <= n_start;
            r_end   <= n_end;
        end
    end

    assign o_done     = r_ok && (r_pos == POS_DONE);
    assign o_start_ms = r_start;
    assign o_end_ms   = r_end;

endmodule

/* design/srt_line_structure_parser.sv */
// An end-of-line request passes the input register, then the result register,
// where its result is held; character requests give no result.
// Throughput: one request per cycle; an end-of-line request waits in the input
// register only while an earlier result is still held by the receiver.
// Reset: synchronous active-low i_rst_n clears line state, error and count.
module srt_line_structure_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  srtlsp_pkg::t_in_item   i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output srtlsp_pkg::t_out_item  o_out_data
);
    import srtlsp_pkg::*;

    localparam int EXT_W = (COUNT_BITS > CUE_W) ? COUNT_BITS : CUE_W;

    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out, n_out;
    logic [2:0]            r_prev_kind, n_prev_kind;
    logic                  r_failed, n_failed;
    logic                  r_only_digits, n_only_digits;
    logic                  r_line_empty, n_line_empty;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic                  w_adv;
    logic                  w_char;
    logic                  w_eol;
    t_tm_ctrl              w_tm_ctrl;
    logic                  w_tm_done;
    logic [MS_W-1:0]       w_start_ms;
    logic [MS_W-1:0]       w_end_ms;
    logic [2:0]            w_kind;
    logic [EXT_W-1:0]      w_count_ext;

    // Advance the held request; an end-of-line request also needs its result slot free
    assign w_adv      = r_in_valid && (!r_in.action || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_char     = w_adv && !r_in.action;
    assign w_eol      = w_adv && r_in.action;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    assign w_tm_ctrl.char_en  = w_char;
    assign w_tm_ctrl.line_clr = w_eol;

    srtlsp_time_match u_time_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_tm_ctrl),
        .i_ch       (r_in.ch),
        .o_done     (w_tm_done),
        .o_start_ms (w_start_ms),
        .o_end_ms   (w_end_ms)
    );

    // Classify the finished line against the expected order
    always_comb begin
        w_kind = KIND_NONE;
        case (r_prev_kind)
            KIND_INDEX:   if (w_tm_done) w_kind = KIND_TIME;
            KIND_TIME:    w_kind = KIND_CONTENT;
            KIND_CONTENT: w_kind = r_line_empty ? KIND_BLANK : KIND_CONTENT;
            default:      if (r_only_digits && !r_line_empty) w_kind = KIND_INDEX;
        endcase
        if (r_failed) w_kind = KIND_NONE;
    end

    // Update line flags, order state and block count
    always_comb begin
        n_prev_kind   = r_prev_kind;
        n_failed      = r_failed;
        n_only_digits = r_only_digits;
        n_line_empty  = r_line_empty;
        n_count       = r_count;
        if (w_char) begin
            n_line_empty = 1'b0;
            if (!is_digit(r_in.ch)) n_only_digits = 1'b0;
        end else if (w_eol) begin
            n_only_digits = 1'b1;
            n_line_empty  = 1'b1;
            if (!r_failed) begin
                if (w_kind == KIND_NONE) begin
                    n_failed = 1'b1;
                end else begin
                    n_prev_kind = w_kind;
                    if ((w_kind == KIND_CONTENT) && (r_prev_kind != KIND_CONTENT)
                        && (r_count != '1)) begin
                        n_count = r_count + COUNT_BITS'(1);
                    end
                end
            end
        end
    end

    assign w_count_ext = EXT_W'(n_count);

    // Build the result
    always_comb begin
        n_out.line_type      = (w_kind == KIND_NONE) ? 2'd0 : 2'(w_kind - 3'd1);
        n_out.error          = n_failed;
        n_out.start_ms       = '0;
        n_out.end_ms         = '0;
        n_out.cue_count      = w_count_ext[CUE_W-1:0];
        n_out.joins_previous = (w_kind == KIND_CONTENT) && (r_prev_kind == KIND_CONTENT);
        if (w_kind == KIND_TIME) begin
            n_out.start_ms = w_start_ms;
            n_out.end_ms   = (w_end_ms < w_start_ms) ? w_start_ms : w_end_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_kind   <= KIND_NONE;
            r_failed      <= 1'b0;
            r_only_digits <= 1'b1;
            r_line_empty  <= 1'b1;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_prev_kind   <= n_prev_kind;
            r_failed      <= n_failed;
            r_only_digits <= n_only_digits;
            r_line_empty  <= n_line_empty;
            r_count       <= n_count;
            if (w_eol) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_eol) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Error is sticky
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("sticky error cleared");

    // A reported error is reflected in the order state
    a_error_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error) |-> r_failed)
        else $error("error reported without failed state");

    // End time never precedes start time
    a_end_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.end_ms >= o_out_data.start_ms))
        else $error("end time below start time");

    // Failed lines carry no times and no join
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error) |->
            ((o_out_data.line_type == 2'd0) && (o_out_data.start_ms == '0)
             && (o_out_data.joins_previous == 1'b0)))
        else $error("failed line with payload");

    // Block count never decreases
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("block count decreased");

endmodule
